[hw/rtl/eoes_pkg.sv]
package eoes_pkg;

    // Default width of the step counter
    localparam int STEP_INDEX_BITS_DEF = 16;

    // Iterations of the shared divide / root unit
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;

    // Configuration register indexes
    localparam logic [2:0] CFG_TIME_STEP  = 3'd0;
    localparam logic [2:0] CFG_GRAV_PARAM = 3'd1;
    localparam logic [2:0] CFG_BODY_MASS  = 3'd2;
    localparam logic [2:0] CFG_INIT_X     = 3'd3;
    localparam logic [2:0] CFG_INIT_Y     = 3'd4;
    localparam logic [2:0] CFG_INIT_VX    = 3'd5;
    localparam logic [2:0] CFG_INIT_VY    = 3'd6;

    // Register reset values (Q8.24)
    localparam logic [30:0] TIME_STEP_RST  = 31'd1677722;
    localparam logic [30:0] GRAV_PARAM_RST = 31'd16777216;
    localparam logic [30:0] BODY_MASS_RST  = 31'd16777216;
    localparam logic [31:0] INIT_X_RST     = 32'd8388608;
    localparam logic [31:0] INIT_Y_RST     = 32'd0;
    localparam logic [31:0] INIT_VX_RST    = 32'd0;
    localparam logic [31:0] INIT_VY_RST    = 32'd27346862;

    // Caps on potential energy and on the intermediate acceleration term
    localparam logic [46:0] PE_CAP    = {1'b1, 46'd0};
    localparam logic [63:0] PE_CAP_64 = {17'd0, 1'b1, 46'd0};
    localparam logic [63:0] T3_CAP    = {23'd0, 1'b1, 40'd0};

    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_M_XX,
        ST_M_YY,
        ST_R2,
        ST_SQRT_W,
        ST_M_VXX,
        ST_M_VYY,
        ST_V2,
        ST_M_KA,
        ST_M_KB,
        ST_KE,
        ST_PE_D,
        ST_PE_W,
        ST_EN,
        ST_M_DX,
        ST_M_DY,
        ST_POS,
        ST_M_T1,
        ST_T1_D,
        ST_T1_W,
        ST_M_T2H,
        ST_M_T2L,
        ST_T2,
        ST_T3_W,
        ST_T4_W,
        ST_VUPD,
        ST_DONE
    } state_t;

    typedef enum logic {
        DS_DIV,
        DS_SQRT
    } ds_mode_t;

    typedef struct packed {
        logic     start;
        ds_mode_t mode;
    } ds_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ds_stat_t;

    // Magnitude of a signed 32-bit word, 2^31 fits
    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    // True when a signed 64-bit value is outside the 32-bit range
    function automatic logic ovf32(input logic [63:0] v);
        return !((&v[63:31]) || !(|v[63:31]));
    endfunction

    function automatic logic [31:0] sat32(input logic [63:0] v);
        logic [31:0] res;
        if (ovf32(v)) begin
            res = v[63] ? S32_MIN : S32_MAX;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

[hw/rtl/eoes_mul.sv]
module eoes_mul (
    input  logic        aclk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);

    logic [63:0] p_reg;

    // Shared 32x32 unsigned multiplier with a registered product
    always_ff @(posedge aclk) begin
        p_reg <= 64'(a) * 64'(b);
    end

    assign p = p_reg;

endmodule

[hw/rtl/eoes_divsqrt.sv]
module eoes_divsqrt (
    input  logic               aclk,
    input  logic               aresetn,
    input  eoes_pkg::ds_ctrl_t ctrl,
    input  logic [63:0]        num,
    input  logic [31:0]        den,
    output eoes_pkg::ds_stat_t stat,
    output logic [63:0]        res
);

    logic               busy_reg;
    logic               done_reg;
    eoes_pkg::ds_mode_t mode_reg;
    logic [6:0]         cnt_reg;
    logic [63:0]        work_reg;
    logic [34:0]        rem_reg;
    logic [63:0]        q_reg;
    logic [31:0]        den_reg;

    logic [32:0] div_trial;
    logic        div_ge;
    logic [34:0] sq_t;
    logic [34:0] sq_trial;
    logic        sq_ge;

    // One quotient bit or one root bit per cycle
    always_comb begin
        div_trial = {rem_reg[31:0], work_reg[63]};
        div_ge    = div_trial >= {1'b0, den_reg};
        sq_t      = {rem_reg[32:0], work_reg[63:62]};
        sq_trial  = {1'b0, q_reg[31:0], 2'b01};
        sq_ge     = sq_t >= sq_trial;
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= (ctrl.mode == eoes_pkg::DS_DIV) ?
                            7'(eoes_pkg::DIV_STEPS) : 7'(eoes_pkg::SQRT_STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            mode_reg <= ctrl.mode;
            work_reg <= num;
            rem_reg  <= 35'd0;
            q_reg    <= 64'd0;
            den_reg  <= den;
        end else if (busy_reg) begin
            if (mode_reg == eoes_pkg::DS_DIV) begin
                work_reg <= {work_reg[62:0], 1'b0};
                if (div_ge) begin
                    rem_reg <= {3'd0, 32'(div_trial - {1'b0, den_reg})};
                    q_reg   <= {q_reg[62:0], 1'b1};
                end else begin
                    rem_reg <= {2'd0, div_trial};
                    q_reg   <= {q_reg[62:0], 1'b0};
                end
            end else begin
                work_reg <= {work_reg[61:0], 2'b00};
                if (sq_ge) begin
                    rem_reg <= sq_t - sq_trial;
                    q_reg   <= {q_reg[62:0], 1'b1};
                end else begin
                    rem_reg <= sq_t;
                    q_reg   <= {q_reg[62:0], 1'b0};
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign res       = q_reg;

endmodule

[hw/rtl/euler_orbit_energy_step_unit.sv]
// Channel   | Ports                  | Word contents (lowest bit up)
// ----------+------------------------+------------------------------------------------
// input     | s_tvalid/tready/tdata  | restart[0]
// result    | m_tvalid/tready/tdata  | step_index[15:0] pos_x pos_y vel_x vel_y
//           |   tuser                |   energy start_energy; tuser: singular
// config    | cfg_we/index/wdata     | register index 0..6, value in low bits
//
// One word at a time. A zero radius skips the potential-energy division and the
// velocity update, and each axis whose acceleration term hits its cap skips one
// division. The time per word is set by the shared divide / root unit: up to
// seven divisions per word and one root.
// Reset (aresetn, synchronous) restores registers and orbit state.
// A result held in the output register does not block the next word; a
// finished word waits only if the previous result has not yet been taken.
module euler_orbit_energy_step_unit #(
    parameter int STEP_INDEX_BITS = eoes_pkg::STEP_INDEX_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // restart
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [207:0] m_tdata,   // step_index, pos_x, pos_y, vel_x, vel_y, energy, start_energy
    output logic [0:0]   m_tuser,   // singular
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    // Configuration
    logic [30:0] time_step_reg, grav_param_reg, body_mass_reg;
    logic [31:0] init_x_reg, init_y_reg, init_vx_reg, init_vy_reg;

    // Orbit state
    logic [31:0] cur_x_reg, cur_y_reg, cur_vx_reg, cur_vy_reg;
    logic [STEP_INDEX_BITS-1:0] step_count_reg;
    logic [31:0] ref_energy_reg;

    // Working registers
    eoes_pkg::state_t state_reg, state_next;
    logic [63:0] acc_reg, tmp_reg, t1_reg, t4_reg;
    logic [31:0] r_reg;
    logic [46:0] ke_reg, pe_reg;
    logic [31:0] energy_reg, nx_reg, ny_reg, nvx_reg, nvy_reg;
    logic        flag_reg;
    logic        axis_reg;

    // Output register
    logic         m_tvalid_reg;
    logic [207:0] m_tdata_reg;
    logic         m_tuser_reg;

    // Shared units
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;
    eoes_pkg::ds_ctrl_t ds_ctrl;
    eoes_pkg::ds_stat_t ds_stat;
    logic [63:0]        ds_num, ds_res;

    eoes_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    eoes_divsqrt u_divsqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ds_ctrl),
        .num     (ds_num),
        .den     (r_reg),
        .stat    (ds_stat),
        .res     (ds_res)
    );

    logic        s_acc, out_free;
    logic [31:0] mx, my, mvx, mvy, mc;
    logic [31:0] cur_c, cur_v;
    logic [95:0] ke_sum;
    logic [48:0] e_diff;
    logic [63:0] e_ext;
    logic [31:0] en_val;
    logic [63:0] pos_ext, pos_d, pos_sum;
    logic [63:0] t2_full;
    logic [63:0] vel_ext, vel_sum;
    logic [31:0] cnt_ext;

    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Operand magnitudes and per-axis selection
    always_comb begin
        mx      = eoes_pkg::mag32(cur_x_reg);
        my      = eoes_pkg::mag32(cur_y_reg);
        mvx     = eoes_pkg::mag32(cur_vx_reg);
        mvy     = eoes_pkg::mag32(cur_vy_reg);
        cur_c   = axis_reg ? cur_y_reg : cur_x_reg;
        cur_v   = axis_reg ? cur_vy_reg : cur_vx_reg;
        mc      = axis_reg ? my : mx;
        ke_sum  = {tmp_reg, 32'd0} + {32'd0, mul_p};
        e_diff  = {2'b00, ke_reg} - {2'b00, pe_reg};
        e_ext   = {{15{e_diff[48]}}, e_diff};
        // energy of this step, most negative when the radius is zero
        en_val  = (r_reg == 32'd0) ? eoes_pkg::S32_MIN : eoes_pkg::sat32(e_ext);
        pos_ext = (state_reg == eoes_pkg::ST_M_DY) ?
                  {{32{cur_x_reg[31]}}, cur_x_reg} : {{32{cur_y_reg[31]}}, cur_y_reg};
        pos_d   = {24'd0, mul_p[63:24]};
        pos_sum = (((state_reg == eoes_pkg::ST_M_DY) ? cur_vx_reg[31] : cur_vy_reg[31])) ?
                  (pos_ext - pos_d) : (pos_ext + pos_d);
        t2_full = {tmp_reg[31:0], 32'd0} + mul_p;
        vel_ext = {{32{cur_v[31]}}, cur_v};
        vel_sum = cur_c[31] ? (vel_ext + t4_reg) : (vel_ext - t4_reg);
        cnt_ext = 32'(step_count_reg);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            eoes_pkg::ST_IDLE:   if (s_acc) state_next = eoes_pkg::ST_M_XX;
            eoes_pkg::ST_M_XX:   state_next = eoes_pkg::ST_M_YY;
            eoes_pkg::ST_M_YY:   state_next = eoes_pkg::ST_R2;
            eoes_pkg::ST_R2:     state_next = eoes_pkg::ST_SQRT_W;
            eoes_pkg::ST_SQRT_W: if (ds_stat.done) state_next = eoes_pkg::ST_M_VXX;
            eoes_pkg::ST_M_VXX:  state_next = eoes_pkg::ST_M_VYY;
            eoes_pkg::ST_M_VYY:  state_next = eoes_pkg::ST_V2;
            eoes_pkg::ST_V2:     state_next = eoes_pkg::ST_M_KA;
            eoes_pkg::ST_M_KA:   state_next = eoes_pkg::ST_M_KB;
            eoes_pkg::ST_M_KB:   state_next = eoes_pkg::ST_KE;
            eoes_pkg::ST_KE:     state_next = eoes_pkg::ST_PE_D;
            eoes_pkg::ST_PE_D: begin
                state_next = (r_reg != 32'd0) ? eoes_pkg::ST_PE_W : eoes_pkg::ST_EN;
            end
            eoes_pkg::ST_PE_W:   if (ds_stat.done) state_next = eoes_pkg::ST_EN;
            eoes_pkg::ST_EN:     state_next = eoes_pkg::ST_M_DX;
            eoes_pkg::ST_M_DX:   state_next = eoes_pkg::ST_M_DY;
            eoes_pkg::ST_M_DY:   state_next = eoes_pkg::ST_POS;
            eoes_pkg::ST_POS: begin
                state_next = (r_reg != 32'd0) ? eoes_pkg::ST_M_T1 : eoes_pkg::ST_DONE;
            end
            eoes_pkg::ST_M_T1:   state_next = eoes_pkg::ST_T1_D;
            eoes_pkg::ST_T1_D:   state_next = eoes_pkg::ST_T1_W;
            eoes_pkg::ST_T1_W:   if (ds_stat.done) state_next = eoes_pkg::ST_M_T2H;
            eoes_pkg::ST_M_T2H:  state_next = eoes_pkg::ST_M_T2L;
            eoes_pkg::ST_M_T2L:  state_next = eoes_pkg::ST_T2;
            eoes_pkg::ST_T2:     state_next = eoes_pkg::ST_T3_W;
            eoes_pkg::ST_T3_W: begin
                if (ds_stat.done) begin
                    state_next = (ds_res >= eoes_pkg::T3_CAP) ?
                                 eoes_pkg::ST_VUPD : eoes_pkg::ST_T4_W;
                end
            end
            eoes_pkg::ST_T4_W:   if (ds_stat.done) state_next = eoes_pkg::ST_VUPD;
            eoes_pkg::ST_VUPD: begin
                state_next = axis_reg ? eoes_pkg::ST_DONE : eoes_pkg::ST_M_T1;
            end
            eoes_pkg::ST_DONE:   if (out_free) state_next = eoes_pkg::ST_IDLE;
            default:             state_next = eoes_pkg::ST_IDLE;
        endcase
    end

    // Unit operands and handshake
    always_comb begin
        s_tready     = (state_reg == eoes_pkg::ST_IDLE);
        mul_a        = 32'd0;
        mul_b        = 32'd0;
        ds_ctrl      = '{start: 1'b0, mode: eoes_pkg::DS_DIV};
        ds_num       = 64'd0;
        unique case (state_reg)
            eoes_pkg::ST_M_XX: begin
                mul_a = mx;
                mul_b = mx;
            end
            eoes_pkg::ST_M_YY: begin
                mul_a = my;
                mul_b = my;
            end
            eoes_pkg::ST_R2: begin
                ds_ctrl = '{start: 1'b1, mode: eoes_pkg::DS_SQRT};
                ds_num  = acc_reg + mul_p;
            end
            eoes_pkg::ST_M_VXX: begin
                mul_a = mvx;
                mul_b = mvx;
            end
            eoes_pkg::ST_M_VYY: begin
                mul_a = mvy;
                mul_b = mvy;
            end
            eoes_pkg::ST_M_KA: begin
                mul_a = {1'b0, body_mass_reg};
                mul_b = acc_reg[63:32];
            end
            eoes_pkg::ST_M_KB: begin
                mul_a = {1'b0, body_mass_reg};
                mul_b = acc_reg[31:0];
            end
            eoes_pkg::ST_KE: begin
                mul_a = {1'b0, grav_param_reg};
                mul_b = {1'b0, body_mass_reg};
            end
            eoes_pkg::ST_PE_D: begin
                ds_ctrl = '{start: (r_reg != 32'd0), mode: eoes_pkg::DS_DIV};
                ds_num  = mul_p;
            end
            eoes_pkg::ST_M_DX: begin
                mul_a = mvx;
                mul_b = {1'b0, time_step_reg};
            end
            eoes_pkg::ST_M_DY: begin
                mul_a = mvy;
                mul_b = {1'b0, time_step_reg};
            end
            eoes_pkg::ST_M_T1: begin
                mul_a = {1'b0, grav_param_reg};
                mul_b = mc;
            end
            eoes_pkg::ST_T1_D: begin
                ds_ctrl = '{start: 1'b1, mode: eoes_pkg::DS_DIV};
                ds_num  = mul_p;
            end
            eoes_pkg::ST_M_T2H: begin
                mul_a = {1'b0, time_step_reg};
                mul_b = t1_reg[63:32];
            end
            eoes_pkg::ST_M_T2L: begin
                mul_a = {1'b0, time_step_reg};
                mul_b = t1_reg[31:0];
            end
            eoes_pkg::ST_T2: begin
                ds_ctrl = '{start: 1'b1, mode: eoes_pkg::DS_DIV};
                ds_num  = {t2_full[63:24], 24'd0};
            end
            eoes_pkg::ST_T3_W: begin
                ds_ctrl = '{start: ds_stat.done && (ds_res < eoes_pkg::T3_CAP),
                            mode: eoes_pkg::DS_DIV};
                ds_num  = {ds_res[39:0], 24'd0};
            end
            default: begin
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg  <= eoes_pkg::TIME_STEP_RST;
            grav_param_reg <= eoes_pkg::GRAV_PARAM_RST;
            body_mass_reg  <= eoes_pkg::BODY_MASS_RST;
            init_x_reg     <= eoes_pkg::INIT_X_RST;
            init_y_reg     <= eoes_pkg::INIT_Y_RST;
            init_vx_reg    <= eoes_pkg::INIT_VX_RST;
            init_vy_reg    <= eoes_pkg::INIT_VY_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                eoes_pkg::CFG_TIME_STEP:  time_step_reg  <= cfg_wdata[30:0];
                eoes_pkg::CFG_GRAV_PARAM: grav_param_reg <= cfg_wdata[30:0];
                eoes_pkg::CFG_BODY_MASS:  body_mass_reg  <= cfg_wdata[30:0];
                eoes_pkg::CFG_INIT_X:     init_x_reg     <= cfg_wdata;
                eoes_pkg::CFG_INIT_Y:     init_y_reg     <= cfg_wdata;
                eoes_pkg::CFG_INIT_VX:    init_vx_reg    <= cfg_wdata;
                eoes_pkg::CFG_INIT_VY:    init_vy_reg    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= eoes_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Orbit state, energy reference and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg      <= eoes_pkg::INIT_X_RST;
            cur_y_reg      <= eoes_pkg::INIT_Y_RST;
            cur_vx_reg     <= eoes_pkg::INIT_VX_RST;
            cur_vy_reg     <= eoes_pkg::INIT_VY_RST;
            step_count_reg <= '0;
            ref_energy_reg <= 32'd0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (s_acc && s_tdata[0]) begin
                cur_x_reg      <= init_x_reg;
                cur_y_reg      <= init_y_reg;
                cur_vx_reg     <= init_vx_reg;
                cur_vy_reg     <= init_vy_reg;
                step_count_reg <= '0;
            end
            if (state_reg == eoes_pkg::ST_EN && step_count_reg == '0) begin
                ref_energy_reg <= en_val;
            end
            if (state_reg == eoes_pkg::ST_DONE && out_free) begin
                m_tvalid_reg   <= 1'b1;
                m_tdata_reg    <= {ref_energy_reg, energy_reg, cur_vy_reg, cur_vx_reg,
                                   cur_y_reg, cur_x_reg, cnt_ext[15:0]};
                m_tuser_reg    <= flag_reg;
                cur_x_reg      <= nx_reg;
                cur_y_reg      <= ny_reg;
                cur_vx_reg     <= nvx_reg;
                cur_vy_reg     <= nvy_reg;
                step_count_reg <= step_count_reg + STEP_INDEX_BITS'(1);
            end
        end
    end

    // Working datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg <= 1'b0;
            axis_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                eoes_pkg::ST_IDLE: begin
                    if (s_acc) begin
                        flag_reg <= 1'b0;
                    end
                    axis_reg <= 1'b0;
                end
                eoes_pkg::ST_M_YY:   acc_reg <= mul_p;
                eoes_pkg::ST_SQRT_W: if (ds_stat.done) r_reg <= ds_res[31:0];
                eoes_pkg::ST_M_VYY:  acc_reg <= mul_p;
                eoes_pkg::ST_V2:     acc_reg <= acc_reg + mul_p;
                eoes_pkg::ST_M_KB:   tmp_reg <= mul_p;
                eoes_pkg::ST_KE:     ke_reg  <= ke_sum[95:49];
                eoes_pkg::ST_PE_W: begin
                    if (ds_stat.done) begin
                        pe_reg <= (ds_res > eoes_pkg::PE_CAP_64) ? eoes_pkg::PE_CAP
                                                                 : ds_res[46:0];
                    end
                end
                eoes_pkg::ST_EN: begin
                    // Radius zero gives the most negative energy and holds velocity
                    nvx_reg <= cur_vx_reg;
                    nvy_reg <= cur_vy_reg;
                    if (r_reg == 32'd0) begin
                        energy_reg <= eoes_pkg::S32_MIN;
                        flag_reg   <= 1'b1;
                    end else begin
                        energy_reg <= eoes_pkg::sat32(e_ext);
                        if (eoes_pkg::ovf32(e_ext)) flag_reg <= 1'b1;
                    end
                end
                eoes_pkg::ST_M_DY: begin
                    nx_reg <= eoes_pkg::sat32(pos_sum);
                    if (eoes_pkg::ovf32(pos_sum)) flag_reg <= 1'b1;
                end
                eoes_pkg::ST_POS: begin
                    ny_reg <= eoes_pkg::sat32(pos_sum);
                    if (eoes_pkg::ovf32(pos_sum)) flag_reg <= 1'b1;
                end
                eoes_pkg::ST_T1_W:   if (ds_stat.done) t1_reg <= ds_res;
                eoes_pkg::ST_M_T2L:  tmp_reg <= mul_p;
                eoes_pkg::ST_T3_W: begin
                    if (ds_stat.done && ds_res >= eoes_pkg::T3_CAP) begin
                        t4_reg <= eoes_pkg::T3_CAP;
                    end
                end
                eoes_pkg::ST_T4_W:   if (ds_stat.done) t4_reg <= ds_res;
                eoes_pkg::ST_VUPD: begin
                    if (axis_reg) begin
                        nvy_reg <= eoes_pkg::sat32(vel_sum);
                    end else begin
                        nvx_reg <= eoes_pkg::sat32(vel_sum);
                    end
                    if (eoes_pkg::ovf32(vel_sum)) flag_reg <= 1'b1;
                    axis_reg <= 1'b1;
                end
                default: begin
                end
            endcase
            // second product of the tick completes the accumulator sum
            if (state_reg == eoes_pkg::ST_R2) begin
                acc_reg <= acc_reg + mul_p;
            end
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // A result only appears after the finishing state
    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == eoes_pkg::ST_DONE))
        else $error("result word raised outside the finishing state");

    // The shared divide / root unit is never restarted while still iterating
    a_ds_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        ds_ctrl.start |-> !ds_stat.busy)
        else $error("divide / root unit started while busy");

    // An accepted word always starts the sequence
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> state_reg == eoes_pkg::ST_M_XX)
        else $error("accepted word did not start the sequence");

endmodule
